>>> src/trlm_pkg.sv
// ============================================================================
// trlm_pkg
// Shared widths, payload types, register indexes and reset values of the
// triangle region luminance block.
// ============================================================================
`default_nettype none

package trlm_pkg;

    localparam int CHAN_W      = 8;
    localparam int WEIGHT_W    = 16;
    localparam int PROD_W      = CHAN_W + WEIGHT_W;
    localparam int LUM_W       = 26;
    // largest luminance: 255 * 65535 on each of the three channels
    localparam longint LUM_MAX = 64'd50134275;

    localparam int SIZE_W      = 11;
    localparam int PASS_CFG_W  = 3;
    // holds any pass count up to eight
    localparam int PASS_CNT_W  = 4;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int NUM_REGIONS = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_WEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_WEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_WEIGHT  = 3'd4;

    localparam logic [SIZE_W-1:0]     IMAGE_SIZE_RESET   = 11'd64;
    localparam logic [PASS_CFG_W-1:0] PASS_COUNT_RESET   = 3'd2;
    localparam logic [WEIGHT_W-1:0]   RED_WEIGHT_RESET   = 16'd19595;
    localparam logic [WEIGHT_W-1:0]   GREEN_WEIGHT_RESET = 16'd38470;
    localparam logic [WEIGHT_W-1:0]   BLUE_WEIGHT_RESET  = 16'd7471;

    typedef enum logic [1:0] {
        REGION_LEFT   = 2'd0,
        REGION_TOP    = 2'd1,
        REGION_RIGHT  = 2'd2,
        REGION_BOTTOM = 2'd3
    } region_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
    } cfg_write_t;

    typedef struct packed {
        logic [LUM_W-1:0] region_left;
        logic [LUM_W-1:0] region_top;
        logic [LUM_W-1:0] region_right;
        logic [LUM_W-1:0] region_bottom;
        logic [LUM_W-1:0] image_brightness;
        logic [LUM_W-1:0] overall_brightness;
        logic             frame_done;
    } result_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] red_weight;
        logic [WEIGHT_W-1:0] green_weight;
        logic [WEIGHT_W-1:0] blue_weight;
    } weights_t;

    // one classified pixel on its way from the front to the back
    typedef struct packed {
        logic [LUM_W-1:0] lum;
        region_t          region;
        logic             last;
    } lum_item_t;

endpackage

`default_nettype wire

>>> src/trlm_stream_if.sv
// ============================================================================
// trlm_stream_if
// Valid/ready channel carrying one payload per transfer.
// ============================================================================
`default_nettype none

interface trlm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/trlm_front.sv
// ============================================================================
// trlm_front
// Accepts pixels, tracks the raster position, picks the triangle and forms
// the weighted luminance over one product stage.
// ============================================================================
`default_nettype none

module trlm_front #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [trlm_pkg::SIZE_W-1:0]   image_size,
    input  trlm_pkg::weights_t            weights,
    trlm_stream_if.sink                   pixel,
    output logic                          push_valid,
    input  logic                          push_ready,
    output trlm_pkg::lum_item_t           push_data
);

    localparam int RW  = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int NW  = RW + 1;
    localparam int ZW  = (NW > trlm_pkg::SIZE_W) ? NW : trlm_pkg::SIZE_W;
    localparam int SGW = RW + 2;
    localparam logic signed [SGW-1:0] S_ONE = SGW'(1);

    logic [RW-1:0] row_reg, row_next;
    logic [RW-1:0] col_reg, col_next;
    logic          a_valid_reg, a_valid_next;
    logic [trlm_pkg::PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    trlm_pkg::region_t region_reg, region_cur;
    logic          last_reg;

    logic [ZW-1:0] size_even, side_wide;
    logic [NW-1:0] side;
    logic          col_wrap, row_wrap, accept, image_end;
    logic signed [SGW-1:0] s_n, s_r, s_c, s_k;
    logic          upper, is_left, is_right;

    // effective side: even, at least two, at most MAX_SIDE
    always_comb
    begin
        size_even = ZW'({image_size[trlm_pkg::SIZE_W-1:1], 1'b0});
        if (size_even < ZW'(2))
        begin
            side_wide = ZW'(2);
        end
        else if (size_even > ZW'(MAX_SIDE))
        begin
            side_wide = ZW'(MAX_SIDE) & ~ZW'(1);
        end
        else
        begin
            side_wide = size_even;
        end
        side = side_wide[NW-1:0];
    end

    // triangle of the current position, in signed arithmetic so that a row
    // beyond a shrunken side still lands somewhere defined
    always_comb
    begin
        s_n   = $signed({1'b0, side});
        s_r   = $signed({2'b00, row_reg});
        s_c   = $signed({2'b00, col_reg});
        upper = row_reg < side[NW-1:1];
        s_k   = upper ? s_r : (s_n - S_ONE - s_r);
        is_left  = s_c < s_k;
        is_right = s_c > (s_n - s_k - S_ONE);
        if (is_left)
        begin
            region_cur = trlm_pkg::REGION_LEFT;
        end
        else if (is_right)
        begin
            region_cur = trlm_pkg::REGION_RIGHT;
        end
        else if (upper)
        begin
            region_cur = trlm_pkg::REGION_TOP;
        end
        else
        begin
            region_cur = trlm_pkg::REGION_BOTTOM;
        end
    end

    assign pixel.ready = !a_valid_reg || push_ready;
    assign accept      = pixel.valid && pixel.ready;
    assign col_wrap    = ({1'b0, col_reg} + NW'(1)) >= side;
    assign row_wrap    = ({1'b0, row_reg} + NW'(1)) >= side;
    assign image_end   = col_wrap && row_wrap;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (col_wrap)
            begin
                col_next = '0;
                row_next = row_wrap ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + RW'(1);
            end
        end
        if (accept)
        begin
            a_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_r_reg <= trlm_pkg::PROD_W'(pixel.data.red) *
                          trlm_pkg::PROD_W'(weights.red_weight);
            prod_g_reg <= trlm_pkg::PROD_W'(pixel.data.green) *
                          trlm_pkg::PROD_W'(weights.green_weight);
            prod_b_reg <= trlm_pkg::PROD_W'(pixel.data.blue) *
                          trlm_pkg::PROD_W'(weights.blue_weight);
            region_reg <= region_cur;
            last_reg   <= image_end;
        end
    end

    assign push_valid     = a_valid_reg;
    assign push_data.lum  = trlm_pkg::LUM_W'(prod_r_reg) + trlm_pkg::LUM_W'(prod_g_reg) +
                            trlm_pkg::LUM_W'(prod_b_reg);
    assign push_data.region = region_reg;
    assign push_data.last   = last_reg;

endmodule

`default_nettype wire

>>> src/trlm_queue.sv
// ============================================================================
// trlm_queue
// Short register queue between the front and the back.
// ============================================================================
`default_nettype none

module trlm_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  trlm_pkg::lum_item_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output trlm_pkg::lum_item_t pop_data
);

    trlm_pkg::lum_item_t entry_reg [trlm_pkg::QUEUE_DEPTH];
    logic [trlm_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [trlm_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign push_ready = count_reg != trlm_pkg::QUEUE_CNT_W'(trlm_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + trlm_pkg::QUEUE_CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - trlm_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + trlm_pkg::QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + trlm_pkg::QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/trlm_accum.sv
// ============================================================================
// trlm_accum
// Per-triangle sums and counts. On the last pixel of an image the totals go
// to the finishing unit and the accumulators start over.
// ============================================================================
`default_nettype none

module trlm_accum #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  trlm_pkg::lum_item_t pop_data,
    input  logic                fin_busy,
    output logic                start,
    output logic [$clog2(MAX_SIDE*MAX_SIDE*trlm_pkg::LUM_MAX+1)-1:0]
                                snap_sum [trlm_pkg::NUM_REGIONS],
    output logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0]
                                snap_cnt [trlm_pkg::NUM_REGIONS]
);

    localparam int CW = $clog2(MAX_SIDE*MAX_SIDE+1);
    localparam int SW = $clog2(MAX_SIDE*MAX_SIDE*trlm_pkg::LUM_MAX+1);

    logic [SW-1:0] sum_reg [trlm_pkg::NUM_REGIONS];
    logic [CW-1:0] cnt_reg [trlm_pkg::NUM_REGIONS];
    logic          take;

    // hold an image end until the finishing unit is free
    assign pop_ready = !(pop_data.last && fin_busy);
    assign take      = pop_valid && pop_ready;
    assign start     = take && pop_data.last;

    always_comb
    begin
        for (int i = 0; i < trlm_pkg::NUM_REGIONS; i++)
        begin
            if (pop_data.region == 2'(i))
            begin
                snap_sum[i] = sum_reg[i] + SW'(pop_data.lum);
                snap_cnt[i] = cnt_reg[i] + CW'(1);
            end
            else
            begin
                snap_sum[i] = sum_reg[i];
                snap_cnt[i] = cnt_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < trlm_pkg::NUM_REGIONS; i++)
            begin
                sum_reg[i] <= '0;
                cnt_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            for (int i = 0; i < trlm_pkg::NUM_REGIONS; i++)
            begin
                sum_reg[i] <= pop_data.last ? '0 : snap_sum[i];
                cnt_reg[i] <= pop_data.last ? '0 : snap_cnt[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> src/trlm_finish.sv
// ============================================================================
// trlm_finish
// End-of-image work: one shared restoring divider for the four averages,
// the pass bookkeeping, a scan for the frame maximum and the result register.
// ============================================================================
`default_nettype none

module trlm_finish #(
    parameter int MAX_SIDE   = 1024,
    parameter int MAX_PASSES = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [$clog2(MAX_SIDE*MAX_SIDE*trlm_pkg::LUM_MAX+1)-1:0]
                                              snap_sum [trlm_pkg::NUM_REGIONS],
    input  logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0]
                                              snap_cnt [trlm_pkg::NUM_REGIONS],
    input  logic [trlm_pkg::PASS_CFG_W-1:0]   pass_count,
    output logic                              busy,
    trlm_stream_if.source                     result
);

    localparam int CW  = $clog2(MAX_SIDE*MAX_SIDE+1);
    localparam int SW  = $clog2(MAX_SIDE*MAX_SIDE*trlm_pkg::LUM_MAX+1);
    localparam int LW  = trlm_pkg::LUM_W;
    localparam int BCW = $clog2(LW);
    localparam int PIW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;
    localparam int PCW = trlm_pkg::PASS_CNT_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIVIDE = 5'b00010,
        ST_PASS   = 5'b00100,
        ST_SCAN   = 5'b01000,
        ST_OUTPUT = 5'b10000
    } fin_state_t;

    fin_state_t    state_reg;
    logic [SW-1:0] sum_reg [trlm_pkg::NUM_REGIONS];
    logic [CW-1:0] cnt_reg [trlm_pkg::NUM_REGIONS];
    logic [1:0]    region_reg;
    logic [BCW-1:0] bit_reg;
    logic [CW-1:0] rem_reg;
    logic [LW-1:0] quo_reg;
    logic [LW-1:0] avg_reg [trlm_pkg::NUM_REGIONS];
    logic [LW-1:0] best_reg;
    logic [PIW-1:0] pass_index_reg;
    logic [LW-1:0] pass_value_reg [MAX_PASSES];
    logic [PIW-1:0] scan_reg;
    logic [LW-1:0] overall_reg;
    logic          done_reg;

    logic [CW-1:0] cnt_cur;
    logic [CW:0]   partial, trial;
    logic          fits;
    logic [CW-1:0] rem_step;
    logic [LW-1:0] quo_step, quotient;
    logic [PCW-1:0] pcfg, passes, pass_inc, scan_inc;
    logic [1:0]    region_inc;
    logic [LW-1:0] scan_value;

    // one quotient bit per cycle; the quotient always fits LW bits since
    // every summed luminance does
    assign cnt_cur  = cnt_reg[region_reg];
    assign partial  = {rem_reg, quo_reg[LW-1]};
    assign trial    = partial - {1'b0, cnt_cur};
    assign fits     = partial >= {1'b0, cnt_cur};
    assign rem_step = fits ? trial[CW-1:0] : partial[CW-1:0];
    assign quo_step = {quo_reg[LW-2:0], fits};
    assign quotient = (cnt_cur == '0) ? '0 : quo_step;
    assign region_inc = region_reg + 2'd1;

    always_comb
    begin
        pcfg = PCW'(pass_count);
        if (pcfg == '0)
        begin
            passes = PCW'(1);
        end
        else if (pcfg > PCW'(MAX_PASSES))
        begin
            passes = PCW'(MAX_PASSES);
        end
        else
        begin
            passes = pcfg;
        end
    end

    assign pass_inc   = PCW'(pass_index_reg) + PCW'(1);
    assign scan_inc   = PCW'(scan_reg) + PCW'(1);
    assign scan_value = pass_value_reg[scan_reg];

    assign busy         = state_reg != ST_IDLE;
    assign result.valid = state_reg == ST_OUTPUT;
    assign result.data.region_left        = avg_reg[trlm_pkg::REGION_LEFT];
    assign result.data.region_top         = avg_reg[trlm_pkg::REGION_TOP];
    assign result.data.region_right       = avg_reg[trlm_pkg::REGION_RIGHT];
    assign result.data.region_bottom      = avg_reg[trlm_pkg::REGION_BOTTOM];
    assign result.data.image_brightness   = best_reg;
    assign result.data.overall_brightness = overall_reg;
    assign result.data.frame_done         = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pass_index_reg <= '0;
            for (int i = 0; i < MAX_PASSES; i++)
            begin
                pass_value_reg[i] <= '0;
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (bit_reg == BCW'(LW - 1) &&
                        region_reg == 2'(trlm_pkg::NUM_REGIONS - 1))
                    begin
                        state_reg <= ST_PASS;
                    end
                end
                ST_PASS:
                begin
                    pass_value_reg[pass_index_reg] <= best_reg;
                    if (pass_inc >= passes)
                    begin
                        pass_index_reg <= '0;
                        state_reg      <= ST_SCAN;
                    end
                    else
                    begin
                        pass_index_reg <= pass_inc[PIW-1:0];
                        state_reg      <= ST_OUTPUT;
                    end
                end
                ST_SCAN:
                begin
                    if (scan_inc >= passes)
                    begin
                        state_reg <= ST_OUTPUT;
                    end
                end
                ST_OUTPUT:
                begin
                    if (result.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    for (int i = 0; i < trlm_pkg::NUM_REGIONS; i++)
                    begin
                        sum_reg[i] <= snap_sum[i];
                        cnt_reg[i] <= snap_cnt[i];
                    end
                    region_reg <= '0;
                    bit_reg    <= '0;
                    rem_reg    <= CW'(snap_sum[0][SW-1:LW]);
                    quo_reg    <= snap_sum[0][LW-1:0];
                    best_reg   <= '0;
                end
            end
            ST_DIVIDE:
            begin
                if (bit_reg == BCW'(LW - 1))
                begin
                    avg_reg[region_reg] <= quotient;
                    if (quotient > best_reg)
                    begin
                        best_reg <= quotient;
                    end
                    // load the next triangle
                    region_reg <= region_inc;
                    bit_reg    <= '0;
                    rem_reg    <= CW'(sum_reg[region_inc][SW-1:LW]);
                    quo_reg    <= sum_reg[region_inc][LW-1:0];
                end
                else
                begin
                    rem_reg <= rem_step;
                    quo_reg <= quo_step;
                    bit_reg <= bit_reg + BCW'(1);
                end
            end
            ST_PASS:
            begin
                overall_reg <= '0;
                scan_reg    <= '0;
                done_reg    <= pass_inc >= passes;
            end
            ST_SCAN:
            begin
                if (scan_value > overall_reg)
                begin
                    overall_reg <= scan_value;
                end
                scan_reg <= scan_inc[PIW-1:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/triangle_region_luminance_max.sv
// ============================================================================
// triangle_region_luminance_max
// Per-image triangle luminance averages and per-frame brightness maximum.
// ============================================================================
// Pixels of a square image arrive in raster order and are taken at one per
// cycle while the queue has room: the front classifies each into the left,
// top, right or bottom triangle and forms its Q10.16 luminance over one
// product stage, and a four-entry queue feeds the accumulators behind it. On
// the last pixel of an image the totals move to a finishing unit whose single
// shared divider yields one quotient bit per cycle, and the scan over the
// pass values runs only on a frame's last image. While that unit works and
// while its result waits to be taken, pixels of the next image keep being
// accumulated; the next image end waits until the result has gone, and the
// pixels behind it stall meanwhile. Configuration writes are taken in any
// cycle and should be made between images. No clearing pass follows reset.
// ============================================================================
`default_nettype none

module triangle_region_luminance_max #(
    parameter int MAX_SIDE   = 1024,
    parameter int MAX_PASSES = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    trlm_stream_if.sink   cfg,
    trlm_stream_if.sink   pixel,
    trlm_stream_if.source result
);

    localparam int CW = $clog2(MAX_SIDE*MAX_SIDE+1);
    localparam int SW = $clog2(MAX_SIDE*MAX_SIDE*trlm_pkg::LUM_MAX+1);

    logic [trlm_pkg::SIZE_W-1:0]     image_size_reg;
    logic [trlm_pkg::PASS_CFG_W-1:0] pass_count_reg;
    trlm_pkg::weights_t              weights_reg;

    logic                push_valid, push_ready;
    trlm_pkg::lum_item_t push_data;
    logic                pop_valid, pop_ready;
    trlm_pkg::lum_item_t pop_data;
    logic                fin_busy, fin_start;
    logic [SW-1:0]       snap_sum [trlm_pkg::NUM_REGIONS];
    logic [CW-1:0]       snap_cnt [trlm_pkg::NUM_REGIONS];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg           <= trlm_pkg::IMAGE_SIZE_RESET;
            pass_count_reg           <= trlm_pkg::PASS_COUNT_RESET;
            weights_reg.red_weight   <= trlm_pkg::RED_WEIGHT_RESET;
            weights_reg.green_weight <= trlm_pkg::GREEN_WEIGHT_RESET;
            weights_reg.blue_weight  <= trlm_pkg::BLUE_WEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                trlm_pkg::REG_IMAGE_SIZE:
                    image_size_reg <= cfg.data.value[trlm_pkg::SIZE_W-1:0];
                trlm_pkg::REG_PASS_COUNT:
                    pass_count_reg <= cfg.data.value[trlm_pkg::PASS_CFG_W-1:0];
                trlm_pkg::REG_RED_WEIGHT:
                    weights_reg.red_weight <= cfg.data.value;
                trlm_pkg::REG_GREEN_WEIGHT:
                    weights_reg.green_weight <= cfg.data.value;
                trlm_pkg::REG_BLUE_WEIGHT:
                    weights_reg.blue_weight <= cfg.data.value;
                default:
                begin
                end
            endcase
        end
    end

    trlm_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .image_size (image_size_reg),
        .weights    (weights_reg),
        .pixel      (pixel),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    trlm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    trlm_accum #(
        .MAX_SIDE (MAX_SIDE)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .fin_busy  (fin_busy),
        .start     (fin_start),
        .snap_sum  (snap_sum),
        .snap_cnt  (snap_cnt)
    );

    trlm_finish #(
        .MAX_SIDE   (MAX_SIDE),
        .MAX_PASSES (MAX_PASSES)
    ) u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (fin_start),
        .snap_sum   (snap_sum),
        .snap_cnt   (snap_cnt),
        .pass_count (pass_count_reg),
        .busy       (fin_busy),
        .result     (result)
    );

endmodule

`default_nettype wire

>>> src/trlm_checker.sv
// ============================================================================
// trlm_checker
// Port-level checks on the result channel of the luminance block.
// ============================================================================
`default_nettype none

module trlm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input trlm_pkg::result_t result_data
);

    // a stalled result stays and holds its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result dropped or changed while stalled");

    // the frame maximum is only shown on the frame's last image
    a_overall_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.frame_done |->
            result_data.overall_brightness == '0)
        else $error("frame maximum shown before frame end");

    // image brightness is the largest of the four triangle averages
    a_image_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            result_data.image_brightness >= result_data.region_left &&
            result_data.image_brightness >= result_data.region_top &&
            result_data.image_brightness >= result_data.region_right &&
            result_data.image_brightness >= result_data.region_bottom &&
            (result_data.image_brightness == result_data.region_left ||
             result_data.image_brightness == result_data.region_top ||
             result_data.image_brightness == result_data.region_right ||
             result_data.image_brightness == result_data.region_bottom))
        else $error("image brightness is not the triangle maximum");

    // each image end needs a fresh division, so results never come back to back
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready |=> !result_valid)
        else $error("result follows the previous transfer too soon");

endmodule

bind triangle_region_luminance_max trlm_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

`default_nettype wire
